/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files.
// No dependencies; pull in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, switched off while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that stays live through reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/hcs_pkg.sv */
// Types, codes and constants for the home clock and schedule controller.
// Used by every module of the block; no dependencies.
`default_nettype none

package hcs_pkg;

   // request kinds
   localparam logic [2:0] KIND_CLOCK_TICK  = 3'd0;
   localparam logic [2:0] KIND_HEATER_TICK = 3'd1;
   localparam logic [2:0] KIND_COMMAND     = 3'd2;
   localparam logic [2:0] KIND_EMERGENCY   = 3'd3;
   localparam logic [2:0] KIND_BUTTON      = 3'd4;

   // event codes
   localparam logic [3:0] EV_NONE          = 4'd0;
   localparam logic [3:0] EV_LIGHT_ON      = 4'd1;
   localparam logic [3:0] EV_LIGHT_OFF     = 4'd2;
   localparam logic [3:0] EV_HEATER_ON     = 4'd3;
   localparam logic [3:0] EV_HEATER_DONE   = 4'd4;
   localparam logic [3:0] EV_EMERGENCY     = 4'd5;
   localparam logic [3:0] EV_FAN_ON        = 4'd6;
   localparam logic [3:0] EV_ALARM_ON      = 4'd7;
   localparam logic [3:0] EV_SCHED_LIGHT   = 4'd8;
   localparam logic [3:0] EV_ALARM_CANCEL  = 4'd9;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_TPS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEATER_TPS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEATER_RUN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAN_ON_HOUR   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAN_OFF_HOUR  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_OFF_HOUR = 3'd5;

   // configuration reset values
   localparam logic [7:0] CLOCK_TPS_RESET      = 8'd15;
   localparam logic [7:0] HEATER_TPS_RESET     = 8'd244;
   localparam logic [5:0] HEATER_RUN_RESET     = 6'd15;
   localparam logic [4:0] FAN_ON_HOUR_RESET    = 5'd18;
   localparam logic [4:0] FAN_OFF_HOUR_RESET   = 5'd7;
   localparam logic [4:0] LIGHT_OFF_HOUR_RESET = 5'd22;

   // clock state reset values and limits
   localparam logic [5:0] SECONDS_RESET = 6'd58;
   localparam logic [5:0] MINUTES_RESET = 6'd59;
   localparam logic [4:0] HOURS_RESET   = 5'd6;
   localparam logic [5:0] LAST_SECOND   = 6'd59;
   localparam logic [5:0] LAST_MINUTE   = 6'd59;
   localparam logic [4:0] LAST_HOUR     = 5'd23;

   // command characters
   localparam logic [7:0] CHAR_L_UPPER = 8'h4C;
   localparam logic [7:0] CHAR_L_LOWER = 8'h6C;
   localparam logic [7:0] CHAR_O_UPPER = 8'h4F;
   localparam logic [7:0] CHAR_O_LOWER = 8'h6F;
   localparam logic [7:0] CHAR_H_UPPER = 8'h48;
   localparam logic [7:0] CHAR_H_LOWER = 8'h68;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] rx_byte;
      logic [1:0] button_lines;
   } req_type;

   typedef struct packed {
      logic       light_on;
      logic       fan_on;
      logic       heater_on;
      logic       alarm_on;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [3:0] event_code;
   } rsp_type;

   typedef struct packed {
      logic [7:0] clock_ticks_per_second;
      logic [7:0] heater_ticks_per_second;
      logic [5:0] heater_run_minutes;
      logic [4:0] fan_on_hour;
      logic [4:0] fan_off_alarm_hour;
      logic [4:0] light_off_hour;
   } cfg_type;

endpackage

`default_nettype wire

/* hw/rtl/hcs_csr.sv */
// Configuration registers of the controller, written over the csr channel.
// Depends on hcs_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module hcs_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [hcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hcs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output hcs_pkg::cfg_type                    cfg
);
   import hcs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CLOCK_TPS:      cfg_in.clock_ticks_per_second  = csr_wdata;
            CSR_HEATER_TPS:     cfg_in.heater_ticks_per_second = csr_wdata;
            CSR_HEATER_RUN:     cfg_in.heater_run_minutes      = csr_wdata[5:0];
            CSR_FAN_ON_HOUR:    cfg_in.fan_on_hour             = csr_wdata[4:0];
            CSR_FAN_OFF_HOUR:   cfg_in.fan_off_alarm_hour      = csr_wdata[4:0];
            CSR_LIGHT_OFF_HOUR: cfg_in.light_off_hour          = csr_wdata[4:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_ticks_per_second  <= CLOCK_TPS_RESET;
         cfg_ff.heater_ticks_per_second <= HEATER_TPS_RESET;
         cfg_ff.heater_run_minutes      <= HEATER_RUN_RESET;
         cfg_ff.fan_on_hour             <= FAN_ON_HOUR_RESET;
         cfg_ff.fan_off_alarm_hour      <= FAN_OFF_HOUR_RESET;
         cfg_ff.light_off_hour          <= LIGHT_OFF_HOUR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/hcs_core.sv */
// Clock, heater timer and output levels; one request handled per enabled cycle.
// Depends on hcs_pkg for codes, reset values and the req/rsp/cfg types.
`default_nettype none

module hcs_core (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      step,
   input  hcs_pkg::req_type req,
   input  hcs_pkg::cfg_type cfg,
   output hcs_pkg::rsp_type rsp
);
   import hcs_pkg::*;

   logic [7:0] tick_ff,     tick_in;
   logic [5:0] sec_ff,      sec_in;
   logic [5:0] min_ff,      min_in;
   logic [4:0] hour_ff,     hour_in;
   logic [7:0] htick_ff,    htick_in;
   logic [5:0] hsec_ff,     hsec_in;
   logic [5:0] hmin_ff,     hmin_in;
   logic       light_ff,    light_in;
   logic       fan_ff,      fan_in;
   logic       heater_ff,   heater_in;
   logic       alarm_ff,    alarm_in;

   logic [3:0] ev;
   logic       sched;
   logic       l0_low;
   logic       l1_low;
   logic [7:0] tick_inc;
   logic [7:0] htick_inc;
   logic [6:0] hmin_inc;

   function automatic logic [4:0] next_hour(input logic [4:0] h);
      next_hour = (h >= LAST_HOUR) ? 5'd0 : h + 5'd1;
   endfunction

   assign l0_low    = ~req.button_lines[0];
   assign l1_low    = ~req.button_lines[1];
   assign tick_inc  = tick_ff + 8'd1;
   assign htick_inc = htick_ff + 8'd1;
   assign hmin_inc  = {1'b0, hmin_ff} + 7'd1;

   always_comb begin
      tick_in   = tick_ff;
      sec_in    = sec_ff;
      min_in    = min_ff;
      hour_in   = hour_ff;
      htick_in  = htick_ff;
      hsec_in   = hsec_ff;
      hmin_in   = hmin_ff;
      light_in  = light_ff;
      fan_in    = fan_ff;
      heater_in = heater_ff;
      alarm_in  = alarm_ff;
      ev        = EV_NONE;
      sched     = 1'b0;

      case (req.kind)
         KIND_CLOCK_TICK: begin
            tick_in = tick_inc;
            if (tick_inc >= cfg.clock_ticks_per_second) begin
               tick_in = 8'd0;
               sched   = 1'b1;
               if (sec_ff >= LAST_SECOND) begin
                  sec_in = 6'd0;
                  if (min_ff >= LAST_MINUTE) begin
                     min_in  = 6'd0;
                     hour_in = next_hour(hour_ff);
                  end else begin
                     min_in = min_ff + 6'd1;
                  end
               end else begin
                  sec_in = sec_ff + 6'd1;
               end
            end
         end
         KIND_HEATER_TICK: begin
            if (heater_ff) begin
               htick_in = htick_inc;
               if (htick_inc >= cfg.heater_ticks_per_second) begin
                  htick_in = 8'd0;
                  if (hsec_ff >= LAST_SECOND) begin
                     hsec_in = 6'd0;
                     // run time reached: stop the heater and clear its timer
                     if (hmin_inc >= {1'b0, cfg.heater_run_minutes}) begin
                        heater_in = 1'b0;
                        hmin_in   = 6'd0;
                        ev        = EV_HEATER_DONE;
                     end else begin
                        hmin_in = hmin_inc[5:0];
                     end
                  end else begin
                     hsec_in = hsec_ff + 6'd1;
                  end
               end
            end
         end
         KIND_COMMAND: begin
            if (req.rx_byte == CHAR_L_UPPER || req.rx_byte == CHAR_L_LOWER) begin
               light_in = 1'b1;
               ev       = EV_LIGHT_ON;
            end else if (req.rx_byte == CHAR_O_UPPER || req.rx_byte == CHAR_O_LOWER) begin
               light_in = 1'b0;
               ev       = EV_LIGHT_OFF;
            end else if (req.rx_byte == CHAR_H_UPPER || req.rx_byte == CHAR_H_LOWER) begin
               heater_in = 1'b1;
               ev        = EV_HEATER_ON;
            end
         end
         KIND_EMERGENCY: begin
            light_in  = 1'b0;
            fan_in    = 1'b0;
            heater_in = 1'b0;
            alarm_in  = 1'b0;
            ev        = EV_EMERGENCY;
         end
         KIND_BUTTON: begin
            // minute step is blocked while the alarm sounds
            if (l1_low && !l0_low && !alarm_ff) begin
               sched = 1'b1;
               if (min_ff >= LAST_MINUTE) begin
                  min_in  = 6'd0;
                  hour_in = next_hour(hour_ff);
               end else begin
                  min_in = min_ff + 6'd1;
               end
            end
            if (l0_low && !l1_low) begin
               sched   = 1'b1;
               hour_in = next_hour(hour_ff);
            end
            if (l0_low && l1_low) begin
               sched   = 1'b1;
               sec_in  = 6'd0;
               min_in  = 6'd0;
               hour_in = 5'd0;
            end
         end
         default: begin
            ev = EV_NONE;
         end
      endcase

      // schedule checks on the updated time, last match wins the event
      if (sched && min_in == 6'd0 && sec_in == 6'd0) begin
         if (hour_in == cfg.fan_on_hour) begin
            fan_in = 1'b1;
            ev     = EV_FAN_ON;
         end
         if (hour_in == cfg.fan_off_alarm_hour) begin
            fan_in   = 1'b0;
            alarm_in = 1'b1;
            ev       = EV_ALARM_ON;
         end
         if (hour_in == cfg.light_off_hour) begin
            light_in = 1'b0;
            ev       = EV_SCHED_LIGHT;
         end
      end

      // cancel may drop an alarm raised just above
      if (req.kind == KIND_BUTTON && alarm_in && l1_low) begin
         alarm_in = 1'b0;
         ev       = EV_ALARM_CANCEL;
      end
   end

   always_comb begin
      rsp.light_on   = light_in;
      rsp.fan_on     = fan_in;
      rsp.heater_on  = heater_in;
      rsp.alarm_on   = alarm_in;
      rsp.hours      = hour_in;
      rsp.minutes    = min_in;
      rsp.seconds    = sec_in;
      rsp.event_code = ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= 8'd0;
         sec_ff    <= SECONDS_RESET;
         min_ff    <= MINUTES_RESET;
         hour_ff   <= HOURS_RESET;
         htick_ff  <= 8'd0;
         hsec_ff   <= 6'd0;
         hmin_ff   <= 6'd0;
         light_ff  <= 1'b0;
         fan_ff    <= 1'b0;
         heater_ff <= 1'b0;
         alarm_ff  <= 1'b0;
      end else if (step) begin
         tick_ff   <= tick_in;
         sec_ff    <= sec_in;
         min_ff    <= min_in;
         hour_ff   <= hour_in;
         htick_ff  <= htick_in;
         hsec_ff   <= hsec_in;
         hmin_ff   <= hmin_in;
         light_ff  <= light_in;
         fan_ff    <= fan_in;
         heater_ff <= heater_in;
         alarm_ff  <= alarm_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/home_clock_schedule_controller.sv */
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  hcs_pkg::req_type
// rsp      out        rsp_valid/rsp_stall  hcs_pkg::rsp_type
// csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One request per cycle sustained while the result side does not stall.
// Each request passes the request register, hcs_core and then the result register.
// Synchronous active-high reset restores the clock to 06:59:58 and all outputs off.
// A stalled result holds in the result register; the request register then holds
// one more request and req_stall rises only when both are full.
// Depends on hcs_pkg, hcs_csr, hcs_core and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module home_clock_schedule_controller (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  hcs_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output hcs_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [hcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hcs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hcs_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    take;
   logic    fire;
   cfg_type cfg;
   rsp_type core_rsp;

   // advance the held request when the result register is free or draining
   assign fire         = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !fire;
   assign take         = req_valid && !req_stall;
   assign in_valid_in  = take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   hcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hcs_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (fire),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= core_rsp;
      end
   end

   `ASSERT_CLKD(a_fire_gives_result, clock, reset, fire |=> rsp_valid, "request advanced without result")
   `ASSERT_CLKD(a_time_in_range, clock, reset, rsp_valid |-> (rsp_data.hours <= LAST_HOUR && rsp_data.minutes <= LAST_MINUTE && rsp_data.seconds <= LAST_SECOND), "clock out of range")
   `ASSERT_CLKD(a_emergency_all_off, clock, reset, (rsp_valid && rsp_data.event_code == EV_EMERGENCY) |-> !(rsp_data.light_on || rsp_data.fan_on || rsp_data.heater_on || rsp_data.alarm_on), "emergency left an output on")
   `ASSERT_CLK(a_reset_empties, clock, reset |=> (!rsp_valid && !req_stall), "pipeline not empty after reset")

endmodule

`default_nettype wire

/* tb/hcs_schedule_checker.sv */
`timescale 1ns / 1ps
// Result checker for the home clock and schedule controller testbench.
// Mirrors register writes and controller state, predicts each result and compares
// it with the block's output. Depends on hcs_pkg.
module hcs_schedule_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  hcs_pkg::req_type                     req_data,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  hcs_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [hcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hcs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                   mismatch_count,
   output int                                   outstanding
);
   import hcs_pkg::*;

   // register mirror
   logic [7:0] tick_limit;
   logic [7:0] heat_tick_limit;
   logic [5:0] heat_run_limit;
   logic [4:0] fan_on_hr;
   logic [4:0] alarm_hr;
   logic [4:0] lights_out_hr;

   // controller state mirror
   logic [7:0] tick_cnt;
   logic [5:0] secs;
   logic [5:0] mins;
   logic [4:0] hrs;
   logic [7:0] heat_tick_cnt;
   logic [5:0] heat_secs;
   logic [5:0] heat_mins;
   logic       light;
   logic       fan;
   logic       heater;
   logic       alarm;

   rsp_type expected_outputs[$];

   function automatic logic [4:0] next_hour(input logic [4:0] h);
      return (h >= LAST_HOUR) ? 5'd0 : h + 5'd1;
   endfunction

   // Fire the time-of-day actions when the clock sits on a whole hour.
   function automatic logic [3:0] schedule_events(input logic [3:0] ev);
      logic [3:0] code;
      code = ev;
      if (mins == 6'd0 && secs == 6'd0) begin
         if (hrs == fan_on_hr) begin
            fan  = 1'b1;
            code = EV_FAN_ON;
         end
         if (hrs == alarm_hr) begin
            fan   = 1'b0;
            alarm = 1'b1;
            code  = EV_ALARM_ON;
         end
         if (hrs == lights_out_hr) begin
            light = 1'b0;
            code  = EV_SCHED_LIGHT;
         end
      end
      return code;
   endfunction

   function automatic rsp_type advance_home_state(input req_type r);
      rsp_type    o;
      logic [3:0] ev;
      logic       line0_low;
      logic       line1_low;
      logic       moved;
      ev        = EV_NONE;
      line0_low = !r.button_lines[0];
      line1_low = !r.button_lines[1];
      moved     = 1'b0;
      case (r.kind)
         KIND_CLOCK_TICK: begin
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt >= tick_limit) begin
               tick_cnt = 8'd0;
               secs = secs + 6'd1;
               if (secs > LAST_SECOND) begin
                  secs = 6'd0;
                  mins = mins + 6'd1;
                  if (mins > LAST_MINUTE) begin
                     mins = 6'd0;
                     hrs  = next_hour(hrs);
                  end
               end
               ev = schedule_events(ev);
            end
         end
         KIND_HEATER_TICK: begin
            if (heater) begin
               heat_tick_cnt = heat_tick_cnt + 8'd1;
               if (heat_tick_cnt >= heat_tick_limit) begin
                  heat_tick_cnt = 8'd0;
                  heat_secs = heat_secs + 6'd1;
                  if (heat_secs > LAST_SECOND) begin
                     heat_secs = 6'd0;
                     heat_mins = heat_mins + 6'd1;
                     if (heat_mins >= heat_run_limit) begin
                        heater    = 1'b0;
                        heat_mins = 6'd0;
                        heat_secs = 6'd0;
                        ev        = EV_HEATER_DONE;
                     end
                  end
               end
            end
         end
         KIND_COMMAND: begin
            if (r.rx_byte == CHAR_L_UPPER || r.rx_byte == CHAR_L_LOWER) begin
               light = 1'b1;
               ev    = EV_LIGHT_ON;
            end else if (r.rx_byte == CHAR_O_UPPER || r.rx_byte == CHAR_O_LOWER) begin
               light = 1'b0;
               ev    = EV_LIGHT_OFF;
            end else if (r.rx_byte == CHAR_H_UPPER || r.rx_byte == CHAR_H_LOWER) begin
               heater = 1'b1;
               ev     = EV_HEATER_ON;
            end
         end
         KIND_EMERGENCY: begin
            light  = 1'b0;
            fan    = 1'b0;
            heater = 1'b0;
            alarm  = 1'b0;
            ev     = EV_EMERGENCY;
         end
         KIND_BUTTON: begin
            // minute step is locked out while the alarm sounds
            if (line1_low && !line0_low && !alarm) begin
               mins = mins + 6'd1;
               if (mins > LAST_MINUTE) begin
                  mins = 6'd0;
                  hrs  = next_hour(hrs);
               end
               moved = 1'b1;
            end
            if (line0_low && !line1_low) begin
               hrs   = next_hour(hrs);
               moved = 1'b1;
            end
            if (line0_low && line1_low) begin
               secs  = 6'd0;
               mins  = 6'd0;
               hrs   = 5'd0;
               moved = 1'b1;
            end
            if (moved)
               ev = schedule_events(ev);
            if (alarm && line1_low) begin
               alarm = 1'b0;
               ev    = EV_ALARM_CANCEL;
            end
         end
         default: ;
      endcase
      o.light_on   = light;
      o.fan_on     = fan;
      o.heater_on  = heater;
      o.alarm_on   = alarm;
      o.hours      = hrs;
      o.minutes    = mins;
      o.seconds    = secs;
      o.event_code = ev;
      return o;
   endfunction

   function automatic string describe(input rsp_type v);
      return $sformatf("light %0b fan %0b heater %0b alarm %0b clock %0d:%0d:%0d event %0d",
                       v.light_on, v.fan_on, v.heater_on, v.alarm_on,
                       v.hours, v.minutes, v.seconds, v.event_code);
   endfunction

   always @(posedge clock) begin : track
      rsp_type want;
      if (reset) begin
         tick_limit      = CLOCK_TPS_RESET;
         heat_tick_limit = HEATER_TPS_RESET;
         heat_run_limit  = HEATER_RUN_RESET;
         fan_on_hr       = FAN_ON_HOUR_RESET;
         alarm_hr        = FAN_OFF_HOUR_RESET;
         lights_out_hr   = LIGHT_OFF_HOUR_RESET;
         tick_cnt        = 8'd0;
         secs            = SECONDS_RESET;
         mins            = MINUTES_RESET;
         hrs             = HOURS_RESET;
         heat_tick_cnt   = 8'd0;
         heat_secs       = 6'd0;
         heat_mins       = 6'd0;
         light           = 1'b0;
         fan             = 1'b0;
         heater          = 1'b0;
         alarm           = 1'b0;
         expected_outputs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CLOCK_TPS:      tick_limit      = csr_wdata;
               CSR_HEATER_TPS:     heat_tick_limit = csr_wdata;
               CSR_HEATER_RUN:     heat_run_limit  = csr_wdata[5:0];
               CSR_FAN_ON_HOUR:    fan_on_hr       = csr_wdata[4:0];
               CSR_FAN_OFF_HOUR:   alarm_hr        = csr_wdata[4:0];
               CSR_LIGHT_OFF_HOUR: lights_out_hr   = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result: %s", $time, describe(rsp_data));
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_data !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: result mismatch\n   expected %s\n   actual   %s",
                              $time, describe(want), describe(rsp_data));
               end
            end
         end
         if (req_valid && !req_stall)
            expected_outputs.push_back(advance_home_state(req_data));
      end
      outstanding = expected_outputs.size();
   end

endmodule

/* tb/home_clock_schedule_controller_tb.sv */
`timescale 1ns / 1ps
// Top of the home clock and schedule controller testbench: clock, reset, register
// phases, request traffic, result stalls and the verdict.
// Depends on hcs_pkg, home_clock_schedule_controller and hcs_schedule_checker.
module home_clock_schedule_controller_tb;
   import hcs_pkg::*;

   localparam int PHASES           = 9;
   localparam int PHASE_ITEMS      = 140;
   localparam int LONG_HOLD_AT     = 420;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int DRAIN_CYCLES     = 8;

   // active-low button line patterns
   localparam logic [1:0] BTN_NONE   = 2'b11;
   localparam logic [1:0] BTN_MINUTE = 2'b01;
   localparam logic [1:0] BTN_HOUR   = 2'b10;
   localparam logic [1:0] BTN_CLEAR  = 2'b00;

   localparam logic [2:0] KIND_SPARE_LOW  = 3'd5;
   localparam logic [2:0] KIND_SPARE_HIGH = 3'd7;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic    tail_phase        = 1'b0;
   int      accepted_requests = 0;
   int      silent_cycles     = 0;
   int      mismatch_count;
   int      outstanding;
   req_type burst[$];

   home_clock_schedule_controller dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata
   );

   hcs_schedule_checker results_check (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata,
      .mismatch_count,
      .outstanding
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         accepted_requests <= accepted_requests + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         silent_cycles <= 0;
      end else if (silent_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         silent_cycles <= silent_cycles + 1;
      end
   end

   // Result side: random stall bursts outside the tail phase, plus one long hold to back the block up.
   initial begin
      bit long_hold_done;
      long_hold_done = 1'b0;
      @(negedge clock);
      forever begin
         if (!long_hold_done && accepted_requests >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   end

   function automatic req_type make_request(input logic [2:0] kind, input logic [7:0] rx,
                                            input logic [1:0] lines);
      req_type r;
      r.kind         = kind;
      r.rx_byte      = rx;
      r.button_lines = lines;
      return r;
   endfunction

   function automatic req_type random_request();
      return make_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                          2'($urandom_range(0, 3)));
   endfunction

   function automatic logic [7:0] command_char();
      case ($urandom_range(0, 5))
         0:       return CHAR_L_UPPER;
         1:       return CHAR_L_LOWER;
         2:       return CHAR_O_UPPER;
         3:       return CHAR_O_LOWER;
         4:       return CHAR_H_UPPER;
         default: return CHAR_H_LOWER;
      endcase
   endfunction

   function automatic cfg_type phase_settings(input int phase);
      cfg_type c;
      case (phase)
         0: c = '{8'd1, 8'd1, 6'd1, 5'd0, 5'd23, 5'd12};
         1: c = '{8'd255, 8'd255, 6'd59, 5'd23, 5'd0, 5'd0};
         2: c = '{8'd2, 8'd1, 6'd2, 5'd5, 5'd5, 5'd5};
         default: begin
            c.clock_ticks_per_second  = 8'($urandom_range(1, 4));
            c.heater_ticks_per_second = 8'($urandom_range(1, 3));
            c.heater_run_minutes      = 6'($urandom_range(1, 2));
            c.fan_on_hour             = 5'($urandom_range(0, 23));
            c.fan_off_alarm_hour      = 5'($urandom_range(0, 23));
            c.light_off_hour          = 5'($urandom_range(0, 23));
         end
      endcase
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic offer(input req_type r, input bit gaps);
      if (gaps && $urandom_range(0, 11) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      send_request(r);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic program_registers(input cfg_type c);
      write_register(CSR_CLOCK_TPS, c.clock_ticks_per_second);
      write_register(CSR_HEATER_TPS, c.heater_ticks_per_second);
      write_register(CSR_HEATER_RUN, 8'(c.heater_run_minutes));
      write_register(CSR_FAN_ON_HOUR, 8'(c.fan_on_hour));
      write_register(CSR_FAN_OFF_HOUR, 8'(c.fan_off_alarm_hour));
      write_register(CSR_LIGHT_OFF_HOUR, 8'(c.light_off_hour));
      csr_valid <= 1'b0;
   endtask

   // Build one well-formed run: a heater run, a time setting session, a clock run,
   // or a short spell of noise.
   task automatic build_burst();
      req_type r;
      int      shape;
      int      pick;
      shape = $urandom_range(0, 9);
      burst.delete();
      if (shape <= 2) begin
         r = random_request();
         r.kind    = KIND_COMMAND;
         r.rx_byte = $urandom_range(0, 1) ? CHAR_H_UPPER : CHAR_H_LOWER;
         burst.push_back(r);
         repeat ($urandom_range(20, 80)) begin
            r = random_request();
            r.kind = ($urandom_range(0, 6) == 0) ? KIND_CLOCK_TICK : KIND_HEATER_TICK;
            burst.push_back(r);
         end
      end else if (shape <= 5) begin
         if ($urandom_range(0, 1)) begin
            r = random_request();
            r.kind    = KIND_COMMAND;
            r.rx_byte = $urandom_range(0, 1) ? CHAR_L_UPPER : CHAR_L_LOWER;
            burst.push_back(r);
         end
         repeat ($urandom_range(4, 30)) begin
            r = random_request();
            r.kind = KIND_BUTTON;
            pick = $urandom_range(0, 19);
            r.button_lines = (pick < 8)  ? BTN_HOUR :
                             (pick < 14) ? BTN_MINUTE :
                             (pick < 17) ? BTN_CLEAR : BTN_NONE;
            burst.push_back(r);
         end
      end else if (shape <= 7) begin
         repeat ($urandom_range(5, 60)) begin
            r = random_request();
            r.kind = KIND_CLOCK_TICK;
            if ($urandom_range(0, 15) == 0) begin
               r.kind    = KIND_COMMAND;
               r.rx_byte = command_char();
            end
            burst.push_back(r);
         end
      end else begin
         repeat ($urandom_range(2, 10)) begin
            r = random_request();
            if (r.kind == KIND_COMMAND && $urandom_range(0, 1))
               r.rx_byte = command_char();
            burst.push_back(r);
         end
      end
   endtask

   initial begin : stimulus
      int  sent;
      bit  paused;
      bit  gaps;
      paused = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every command, ignored bytes and kinds, emergency, each button
      // pattern, and the alarm raised at 07:00:00 then cancelled
      send_request(make_request(KIND_COMMAND, CHAR_L_UPPER, BTN_NONE));
      send_request(make_request(KIND_COMMAND, CHAR_O_LOWER, BTN_NONE));
      send_request(make_request(KIND_COMMAND, CHAR_L_LOWER, BTN_NONE));
      send_request(make_request(KIND_COMMAND, CHAR_O_UPPER, BTN_NONE));
      send_request(make_request(KIND_COMMAND, CHAR_H_UPPER, BTN_NONE));
      send_request(make_request(KIND_COMMAND, CHAR_H_LOWER, BTN_NONE));
      send_request(make_request(KIND_COMMAND, 8'h00, BTN_CLEAR));
      send_request(make_request(KIND_COMMAND, 8'hFF, BTN_NONE));
      send_request(make_request(KIND_HEATER_TICK, 8'h00, BTN_NONE));
      send_request(make_request(KIND_EMERGENCY, 8'h00, BTN_NONE));
      send_request(make_request(KIND_HEATER_TICK, 8'hFF, BTN_CLEAR));
      send_request(make_request(KIND_SPARE_LOW, 8'hFF, BTN_CLEAR));
      send_request(make_request(KIND_SPARE_HIGH, 8'hFF, BTN_CLEAR));
      send_request(make_request(KIND_BUTTON, 8'h00, BTN_NONE));
      send_request(make_request(KIND_BUTTON, 8'h00, BTN_MINUTE));
      send_request(make_request(KIND_BUTTON, 8'h00, BTN_HOUR));
      send_request(make_request(KIND_BUTTON, 8'h00, BTN_CLEAR));
      repeat (7) send_request(make_request(KIND_BUTTON, 8'h00, BTN_HOUR));
      send_request(make_request(KIND_BUTTON, 8'h00, BTN_MINUTE));

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         program_registers(phase_settings(phase));
         gaps = (phase != PHASES - 1);
         if (!gaps)
            tail_phase <= 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_burst();
            foreach (burst[i]) begin
               offer(burst[i], gaps);
               sent++;
            end
            // hold the sender once until every result is back
            if (phase == 4 && !paused && sent >= PHASE_ITEMS / 2) begin
               paused = 1'b1;
               drain_results();
            end
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
